@@ design/geodetic_to_ecef_assert.svh @@
// Assertion macros used by the geodetic to ECEF top level.
`ifndef GEODETIC_TO_ECEF_ASSERT_SVH
`define GEODETIC_TO_ECEF_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define G2E_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("geodetic_to_ecef: implication check failed");

// Next-cycle implication, held off while reset is asserted.
`define G2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("geodetic_to_ecef: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define G2E_ASSERT_AFTER(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("geodetic_to_ecef: reset check failed");

`endif

@@ design/g2e_pkg.sv @@
// Shared constants, types and pipeline latencies of the geodetic to ECEF converter.
package g2e_pkg;

    // Fixed-point constants in Q2.60.
    localparam logic [63:0] Q_ONE   = 64'h1000_0000_0000_0000;
    localparam logic [63:0] Q_THREE = 64'h3000_0000_0000_0000;
    localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SEMI = 2'd0,
        CFG_ECC  = 2'd1,
        CFG_OME  = 2'd2
    } t_cfg_idx;

    // Register reset values (WGS84).
    localparam logic [35:0] SEMI_RESET = 36'd6378137000;
    localparam logic [31:0] ECC_RESET  = 32'd28752143;
    localparam logic [31:0] OME_RESET  = 32'd4266215153;
    localparam logic [31:0] ECC_LIMIT  = 32'h8000_0000;

    // Pipeline latencies in cycles.
    localparam int MUL_LAT      = 3;
    localparam int DIV_LAT      = 6;
    localparam int HORNER_STEPS = 8;
    localparam int ITER_LAT     = MUL_LAT + DIV_LAT + 1;
    localparam int TRIG_LAT     = 1 + 2 * MUL_LAT + HORNER_STEPS * ITER_LAT + MUL_LAT + 1;
    localparam int NEWTON_STEPS = 8;
    localparam int NEWT_LAT     = 2 * MUL_LAT + 1 + MUL_LAT;
    localparam int W_LAT        = TRIG_LAT + 2 * MUL_LAT + 1;
    localparam int N_LAT        = W_LAT + NEWTON_STEPS * NEWT_LAT + MUL_LAT;
    localparam int TOTAL_LAT    = N_LAT + 2 * MUL_LAT + 2;

    // Sine and cosine pair in Q2.60.
    typedef struct packed {
        logic [63:0] sin_v;
        logic [63:0] cos_v;
    } t_sincos;

endpackage

@@ design/g2e_delay.sv @@
// Enabled shift register that aligns a value with the rest of the pipeline.
module g2e_delay #(
    parameter int W = 64,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [N];

    // Each stage takes the one before it when the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[N-1];

endmodule

@@ design/g2e_mulsh.sv @@
// Three-stage signed 64x64 multiplier with right shift of the magnitude, rounded when Round is set.
module g2e_mulsh #(
    parameter int unsigned Shift = 60,
    parameter bit          Round = 1'b1
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    localparam logic [127:0] Half = Round ? (128'd1 << (Shift - 1)) : 128'd0;

    logic [63:0]  n_mag_a, n_mag_b;
    logic [63:0]  r_pp00, r_pp01, r_pp10, r_pp11;
    logic         r_neg1, r_neg2;
    logic [127:0] n_sum, r_sum;
    logic [63:0]  n_shr, n_res, r_res;

    // Stage one: magnitudes and the four 32x32 partial products.
    always_comb begin
        n_mag_a = i_a[63] ? (~i_a + 64'd1) : i_a;
        n_mag_b = i_b[63] ? (~i_b + 64'd1) : i_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp00 <= n_mag_a[31:0]  * n_mag_b[31:0];
            r_pp01 <= n_mag_a[31:0]  * n_mag_b[63:32];
            r_pp10 <= n_mag_a[63:32] * n_mag_b[31:0];
            r_pp11 <= n_mag_a[63:32] * n_mag_b[63:32];
            r_neg1 <= i_a[63] ^ i_b[63];
        end
    end

    // Stage two: full product plus the rounding half.
    assign n_sum = {64'd0, r_pp00} + {32'd0, r_pp01, 32'd0} + {32'd0, r_pp10, 32'd0}
                 + {r_pp11, 64'd0} + Half;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_neg2 <= r_neg1;
        end
    end

    // Stage three: shift down and restore the sign.
    always_comb begin
        n_shr = 64'(r_sum >> Shift);
        n_res = r_neg2 ? (~n_shr + 64'd1) : n_shr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_p = r_res;

endmodule

@@ design/g2e_divc.sv @@
// Pipelined signed division by a small constant, truncating toward zero.
module g2e_divc #(
    parameter int unsigned Divisor = 6
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_v,
    output logic [63:0] o_q
);

    // Reciprocal scaled by 2^63; the estimate is low by at most one.
    localparam logic [63:0] Recip = 64'h8000_0000_0000_0000 / Divisor;
    localparam logic [63:0] DivW  = 64'(Divisor);

    logic [63:0] n_mag, r_mag;
    logic        r_neg;
    logic [63:0] w_est;
    logic [64:0] w_mag_d;
    logic [63:0] n_rem, r_rem, r_est;
    logic        r_neg5;
    logic [63:0] n_quo, n_res, r_res;

    // Split off the sign.
    assign n_mag = i_v[63] ? (~i_v + 64'd1) : i_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_neg <= i_v[63];
        end
    end

    // Quotient estimate by multiplication with the reciprocal.
    g2e_mulsh #(.Shift(63), .Round(1'b0)) u_est (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (r_mag),
        .i_b   (Recip),
        .o_p   (w_est)
    );

    g2e_delay #(.W(65), .N(3)) u_mag_dly (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_neg, r_mag}),
        .o_q   (w_mag_d)
    );

    // Remainder of the estimate.
    assign n_rem = w_mag_d[63:0] - 64'(w_est * DivW);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_est  <= w_est;
            r_rem  <= n_rem;
            r_neg5 <= w_mag_d[64];
        end
    end

    // One correction step, then the sign goes back on.
    always_comb begin
        n_quo = r_est + 64'(r_rem >= DivW);
        n_res = r_neg5 ? (~n_quo + 64'd1) : n_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_q = r_res;

endmodule

@@ design/g2e_trig.sv @@
// Pipelined sine and cosine of a binary angle by quadrant fold and Taylor series.
module g2e_trig #(
    parameter int AngleBits = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_angle,
    output g2e_pkg::t_sincos o_sc
);

    import g2e_pkg::*;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    logic [63:0] n_ext, n_phase, n_sh, n_d;
    logic [63:0] r_d;
    logic [1:0]  r_quad;
    logic [63:0] w_x, w_x2_0, w_x_d, w_s, w_c_d;
    logic [1:0]  w_quad_d;
    logic [63:0] w_x2 [HORNER_STEPS];
    logic [63:0] w_ts [HORNER_STEPS+1];
    logic [63:0] w_tc [HORNER_STEPS+1];
    t_sincos     n_sc, r_sc;

    // Phase in turns, nearest quadrant and the residual angle.
    always_comb begin
        n_ext   = {{32{i_angle[31]}}, i_angle};
        n_phase = n_ext << (64 - AngleBits);
        n_sh    = n_phase + (64'd1 << 61);
        n_d     = {{3{~n_sh[61]}}, n_sh[60:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= n_d;
            r_quad <= n_sh[63:62];
        end
    end

    // Residual to radians, then its square.
    g2e_mulsh #(.Shift(63), .Round(1'b1)) u_rad (
        .i_clk (i_clk), .i_en (i_en), .i_a (r_d), .i_b (PI_Q60), .o_p (w_x)
    );

    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_sq (
        .i_clk (i_clk), .i_en (i_en), .i_a (w_x), .i_b (w_x), .o_p (w_x2_0)
    );

    assign w_x2[0] = w_x2_0;
    assign w_ts[0] = Q_ONE;
    assign w_tc[0] = Q_ONE;

    // Horner steps, highest order term first.
    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_horner
        localparam int unsigned K      = HORNER_STEPS - g;
        localparam int unsigned DivSin = 2 * K * (2 * K + 1);
        localparam int unsigned DivCos = (2 * K - 1) * (2 * K);

        logic [63:0] w_ps, w_pc, w_ds, w_dc;
        logic [63:0] r_ts, r_tc;

        g2e_mulsh #(.Shift(60), .Round(1'b1)) u_ms (
            .i_clk (i_clk), .i_en (i_en), .i_a (w_x2[g]), .i_b (w_ts[g]), .o_p (w_ps)
        );
        g2e_mulsh #(.Shift(60), .Round(1'b1)) u_mc (
            .i_clk (i_clk), .i_en (i_en), .i_a (w_x2[g]), .i_b (w_tc[g]), .o_p (w_pc)
        );
        g2e_divc #(.Divisor(DivSin)) u_ds (
            .i_clk (i_clk), .i_en (i_en), .i_v (w_ps), .o_q (w_ds)
        );
        g2e_divc #(.Divisor(DivCos)) u_dc (
            .i_clk (i_clk), .i_en (i_en), .i_v (w_pc), .o_q (w_dc)
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ts <= Q_ONE - w_ds;
                r_tc <= Q_ONE - w_dc;
            end
        end

        assign w_ts[g+1] = r_ts;
        assign w_tc[g+1] = r_tc;

        if (g < HORNER_STEPS - 1) begin : g_x2
            g2e_delay #(.W(64), .N(ITER_LAT)) u_x2_dly (
                .i_clk (i_clk), .i_en (i_en), .i_d (w_x2[g]), .o_q (w_x2[g+1])
            );
        end
    end

    // Sine needs one more multiply by the angle.
    g2e_delay #(.W(64), .N(HORNER_STEPS * ITER_LAT + MUL_LAT)) u_x_dly (
        .i_clk (i_clk), .i_en (i_en), .i_d (w_x), .o_q (w_x_d)
    );

    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_sin (
        .i_clk (i_clk), .i_en (i_en), .i_a (w_x_d), .i_b (w_ts[HORNER_STEPS]), .o_p (w_s)
    );

    g2e_delay #(.W(64), .N(MUL_LAT)) u_c_dly (
        .i_clk (i_clk), .i_en (i_en), .i_d (w_tc[HORNER_STEPS]), .o_q (w_c_d)
    );

    g2e_delay #(.W(2), .N(TRIG_LAT - 2)) u_quad_dly (
        .i_clk (i_clk), .i_en (i_en), .i_d (r_quad), .o_q (w_quad_d)
    );

    // Unfold the quadrant.
    always_comb begin
        case (t_quad'(w_quad_d))
            QUAD_0: begin
                n_sc.sin_v = w_s;
                n_sc.cos_v = w_c_d;
            end
            QUAD_1: begin
                n_sc.sin_v = w_c_d;
                n_sc.cos_v = ~w_s + 64'd1;
            end
            QUAD_2: begin
                n_sc.sin_v = ~w_s + 64'd1;
                n_sc.cos_v = ~w_c_d + 64'd1;
            end
            default: begin
                n_sc.sin_v = ~w_c_d + 64'd1;
                n_sc.cos_v = w_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc <= n_sc;
        end
    end

    assign o_sc = r_sc;

endmodule

@@ design/geodetic_to_ecef.sv @@
// Top level of the geodetic to Earth-centred Cartesian converter.
//
// Each word on the s_axis channel carries latitude, longitude (binary angles,
// 2^(ANGLE_BITS-1) is pi) and height in millimetres. Each word on the m_axis
// channel carries X, Y and Z in signed millimetres, one result per input word,
// in the same order.
// The ellipsoid is set by three registers on the write port: index 0 is the
// semi-major axis, 1 is e2 and 2 is 1-e2; write them only while no word is in
// flight. Index 3 is ignored.
// The block is one pipeline of 190 register stages, from the input word register
// to the output register, and one word is accepted every cycle while the output
// does not stall. The depth is set by the Taylor series for sine and cosine
// (eight Horner steps, each a multiply and a constant division) and the eight
// Newton steps for 1/sqrt.
// When the result at the output is not taken, the whole pipeline holds and
// s_axis_tready goes low; nothing is lost or repeated.
// Reset empties the pipeline and restores the WGS84 registers.
`include "geodetic_to_ecef_assert.svh"

module geodetic_to_ecef #(
    parameter int ANGLE_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // latitude, longitude, height_mm
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // x_mm, y_mm, z_mm
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [35:0]  i_cfg_data
);

    import g2e_pkg::*;

    logic        w_en;
    logic [35:0] r_semi;
    logic [31:0] r_ecc, r_ome, w_ecc_c;
    logic [63:0] w_e2w, w_omew, w_semiw;
    logic [31:0] r_lat, r_lon, r_hgt;
    logic [TOTAL_LAT:0] r_vld, n_vld;
    t_sincos     w_lat_sc, w_lon_sc;
    logic [63:0] w_h, w_h_d, w_h_d2;
    logic [63:0] w_ss, w_ew, r_w;
    logic [63:0] w_nw [NEWTON_STEPS];
    logic [63:0] w_ny [NEWTON_STEPS+1];
    logic [63:0] w_n, r_nh, w_sum1, w_nz, r_sum2;
    logic [63:0] w_clat_d, w_clon_d, w_slon_d, w_slat_d;
    logic [63:0] w_vx, w_vy, w_vz, n_rx, n_ry, n_rz;
    logic [39:0] r_x, r_y, r_z;

    // The pipeline moves unless a finished word waits at the output.
    assign w_en          = !r_vld[TOTAL_LAT] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[TOTAL_LAT];
    assign m_axis_tdata  = {r_z, r_y, r_x};

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semi <= SEMI_RESET;
            r_ecc  <= ECC_RESET;
            r_ome  <= OME_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEMI: r_semi <= i_cfg_data;
                CFG_ECC:  r_ecc  <= i_cfg_data[31:0];
                CFG_OME:  r_ome  <= i_cfg_data[31:0];
                default:  ;
            endcase
        end
    end

    // Register values widened to Q2.60 and 64-bit operands.
    assign w_ecc_c = (r_ecc > ECC_LIMIT) ? ECC_LIMIT : r_ecc;
    assign w_e2w   = {4'd0, w_ecc_c, 28'd0};
    assign w_omew  = {4'd0, r_ome, 28'd0};
    assign w_semiw = {28'd0, r_semi};

    // Valid bits travel alongside the data.
    assign n_vld = {r_vld[TOTAL_LAT-1:0], s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    // Input word register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lat <= s_axis_tdata[31:0];
            r_lon <= s_axis_tdata[63:32];
            r_hgt <= s_axis_tdata[95:64];
        end
    end

    // Sine and cosine of both angles.
    g2e_trig #(.AngleBits(ANGLE_BITS)) u_trig_lat (
        .i_clk (i_clk), .i_en (w_en), .i_angle (r_lat), .o_sc (w_lat_sc)
    );
    g2e_trig #(.AngleBits(ANGLE_BITS)) u_trig_lon (
        .i_clk (i_clk), .i_en (w_en), .i_angle (r_lon), .o_sc (w_lon_sc)
    );

    // Height with 20 fraction bits, delayed to meet N.
    assign w_h = {{12{r_hgt[31]}}, r_hgt, 20'd0};

    g2e_delay #(.W(64), .N(N_LAT)) u_h_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_h), .o_q (w_h_d)
    );
    g2e_delay #(.W(64), .N(MUL_LAT)) u_h_dly2 (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_h_d), .o_q (w_h_d2)
    );

    // w = 1 - e2 * sin^2(lat).
    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_ss (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_lat_sc.sin_v), .i_b (w_lat_sc.sin_v),
        .o_p (w_ss)
    );
    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_ew (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_e2w), .i_b (w_ss), .o_p (w_ew)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_w <= Q_ONE - w_ew;
        end
    end

    assign w_nw[0] = r_w;
    assign w_ny[0] = Q_ONE;

    // Newton steps for 1/sqrt(w): y = y * (3 - w*y*y) / 2.
    for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_newton
        logic [63:0] w_yy, w_wd, w_wyy, w_yd, w_ynew;
        logic [63:0] r_t;

        g2e_mulsh #(.Shift(60), .Round(1'b1)) u_yy (
            .i_clk (i_clk), .i_en (w_en), .i_a (w_ny[i]), .i_b (w_ny[i]), .o_p (w_yy)
        );
        g2e_delay #(.W(64), .N(MUL_LAT)) u_w_dly (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_nw[i]), .o_q (w_wd)
        );
        g2e_mulsh #(.Shift(60), .Round(1'b1)) u_wyy (
            .i_clk (i_clk), .i_en (w_en), .i_a (w_wd), .i_b (w_yy), .o_p (w_wyy)
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_t <= Q_THREE - w_wyy;
            end
        end

        g2e_delay #(.W(64), .N(2 * MUL_LAT + 1)) u_y_dly (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_ny[i]), .o_q (w_yd)
        );
        g2e_mulsh #(.Shift(61), .Round(1'b1)) u_ynew (
            .i_clk (i_clk), .i_en (w_en), .i_a (w_yd), .i_b (r_t), .o_p (w_ynew)
        );

        assign w_ny[i+1] = w_ynew;

        if (i < NEWTON_STEPS - 1) begin : g_w
            g2e_delay #(.W(64), .N(NEWT_LAT)) u_w_next (
                .i_clk (i_clk), .i_en (w_en), .i_d (w_nw[i]), .o_q (w_nw[i+1])
            );
        end
    end

    // Prime-vertical radius in mm with 20 fraction bits.
    g2e_mulsh #(.Shift(40), .Round(1'b1)) u_n (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_semiw), .i_b (w_ny[NEWTON_STEPS]), .o_p (w_n)
    );

    // Trig values delayed to meet the radius terms.
    g2e_delay #(.W(64), .N(N_LAT + 1 - TRIG_LAT)) u_clat_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_lat_sc.cos_v), .o_q (w_clat_d)
    );
    g2e_delay #(.W(64), .N(N_LAT + 1 + MUL_LAT - TRIG_LAT)) u_clon_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_lon_sc.cos_v), .o_q (w_clon_d)
    );
    g2e_delay #(.W(64), .N(N_LAT + 1 + MUL_LAT - TRIG_LAT)) u_slon_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_lon_sc.sin_v), .o_q (w_slon_d)
    );
    g2e_delay #(.W(64), .N(N_LAT + 1 + MUL_LAT - TRIG_LAT)) u_slat_dly (
        .i_clk (i_clk), .i_en (w_en), .i_d (w_lat_sc.sin_v), .o_q (w_slat_d)
    );

    // Equatorial term (N + h) * cos(lat).
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nh <= w_n + w_h_d;
        end
    end

    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_sum1 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_nh), .i_b (w_clat_d), .o_p (w_sum1)
    );

    // Polar term N * (1 - e2) + h.
    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_nz (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_n), .i_b (w_omew), .o_p (w_nz)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum2 <= w_nz + w_h_d2;
        end
    end

    // Final products.
    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_vx (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_sum1), .i_b (w_clon_d), .o_p (w_vx)
    );
    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_vy (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_sum1), .i_b (w_slon_d), .o_p (w_vy)
    );
    g2e_mulsh #(.Shift(60), .Round(1'b1)) u_vz (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_sum2), .i_b (w_slat_d), .o_p (w_vz)
    );

    // Round to whole millimetres, half upward.
    always_comb begin
        n_rx = w_vx + (64'd1 << 19);
        n_ry = w_vy + (64'd1 << 19);
        n_rz = w_vz + (64'd1 << 19);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x <= n_rx[59:20];
            r_y <= n_ry[59:20];
            r_z <= n_rz[59:20];
        end
    end

    // A waiting result freezes the input side.
    `G2E_ASSERT_IMPLY(a_stall_holds_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // A write to the eccentricity register lands in the next cycle.
    `G2E_ASSERT_NEXT(a_cfg_ecc_write, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == CFG_ECC), r_ecc == $past(i_cfg_data[31:0]))
    // Reset empties the pipeline.
    `G2E_ASSERT_AFTER(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule
